>>> sv/wrip_pkg.sv
// ----------------------------------------------------------------------------
// wrip_pkg
// Shared types and constants of the weighted random index picker.
// ----------------------------------------------------------------------------
package wrip_pkg;

  // Table geometry.
  localparam int MAX_ENTRIES = 64;
  localparam int WEIGHT_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Field widths of the transactions.
  localparam int IN_WEIGHT_W = 16;
  localparam int DRAW_W      = 22;

  // A running sum of all entries never overflows at this width.
  localparam int SUM_W       = WEIGHT_BITS + IDX_W;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_DELETE = 2'd2,
    OP_PICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_DEL,
    S_DONE
  } state_t;

endpackage

>>> sv/wrip_req_if.sv
// ----------------------------------------------------------------------------
// wrip_req_if
// Request channel: one operation on the weight table per transaction.
// ----------------------------------------------------------------------------
interface wrip_req_if import wrip_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic [IDX_W-1:0]       entry_index;
  logic [IN_WEIGHT_W-1:0] entry_weight;
  logic [DRAW_W-1:0]      draw;

  modport source (output valid, op, entry_index, entry_weight, draw, input ready);
  modport sink   (input valid, op, entry_index, entry_weight, draw, output ready);

endinterface

>>> sv/wrip_rsp_if.sv
// ----------------------------------------------------------------------------
// wrip_rsp_if
// Response channel: one result per request transaction.
// ----------------------------------------------------------------------------
interface wrip_rsp_if import wrip_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [IDX_W-1:0] picked_index;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, status, picked_index, entry_count, input ready);
  modport sink   (input valid, status, picked_index, entry_count, output ready);

endinterface

>>> sv/wrip_ram.sv
// ----------------------------------------------------------------------------
// wrip_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wrip_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/weighted_random_index_picker.sv
// ----------------------------------------------------------------------------
// weighted_random_index_picker
// Ordered weight table with append, delete, clear and roulette-wheel pick.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transaction carries
//  req      sink       op, entry_index, entry_weight, draw
//  rsp      source     status, picked_index, entry_count
//
//  Clear, append, rejected operations and a delete of the last entry go
//  from accept straight to the done state.
//  A pick scans k entries from index 0 (k from 1 to entry_count) until the
//  running sum exceeds the draw or the last entry is reached; the weight RAM
//  delivers one stored weight per cycle to the adder. A delete at index i
//  that moves entries does one RAM read and write per moved entry.
//  The next request can be accepted in the same cycle as its result is presented.
//  Synchronous reset empties the table; weights are not cleared.
//  A result waiting in the output register does not block the next request;
//  the block stalls only when a second result is ready before it is taken.
// ----------------------------------------------------------------------------
module weighted_random_index_picker import wrip_pkg::*; (
  input  logic clk,
  input  logic rst,
  wrip_req_if.sink   req,
  wrip_rsp_if.source rsp
);

  state_t state, state_next;

  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] ptr, ptr_next;
  logic [SUM_W-1:0] sum, sum_next;
  logic [DRAW_W-1:0] draw_q;
  status_t           res_status, res_status_next;
  logic [IDX_W-1:0]  res_picked, res_picked_next;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [WEIGHT_BITS-1:0] ram_wdata, ram_rdata;

  logic    accept;
  op_t     op;
  logic    append_ok, del_ok, del_shift, pick_ok;
  logic    pick_hit, pick_last, del_last;
  logic    out_free;

  wrip_ram #(
    .DEPTH(MAX_ENTRIES),
    .WIDTH(WEIGHT_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Request decode and checks against the current table size.
  assign accept    = req.valid && req.ready;
  assign op        = op_t'(req.op);
  assign append_ok = count < CNT_W'(MAX_ENTRIES);
  assign del_ok    = CNT_W'(req.entry_index) < count;
  assign del_shift = (CNT_W'(req.entry_index) + CNT_W'(1)) < count;
  assign pick_ok   = count != '0;
  assign req.ready = (state == S_IDLE);

  // Scan and shift termination.
  assign sum_next  = sum + SUM_W'(ram_rdata);
  assign pick_hit  = SUM_W'(draw_q) < sum_next;
  assign pick_last = (CNT_W'(ptr) + CNT_W'(1)) == count;
  assign del_last  = (CNT_W'(ptr) + CNT_W'(2)) == count;

  assign out_free  = !rsp.valid || rsp.ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_PICK && pick_ok) begin
            state_next = S_PICK;
          end else if (op == OP_DELETE && del_shift) begin
            state_next = S_DEL;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_PICK: begin
        if (pick_hit || pick_last) begin
          state_next = S_DONE;
        end
      end
      S_DEL: begin
        if (del_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // RAM accesses and datapath updates for each state.
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = ptr;
    ram_wdata       = ram_rdata;
    ram_raddr       = IDX_W'(CNT_W'(ptr) + CNT_W'(1));
    count_next      = count;
    ptr_next        = ptr;
    res_status_next = res_status;
    res_picked_next = res_picked;
    case (state)
      S_IDLE: begin
        ptr_next = '0;
        if (op == OP_DELETE) begin
          ram_raddr = IDX_W'(CNT_W'(req.entry_index) + CNT_W'(1));
        end else begin
          ram_raddr = '0;
        end
        if (accept) begin
          res_picked_next = '0;
          res_status_next = ST_OK;
          case (op)
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_APPEND: begin
              if (append_ok) begin
                ram_we     = 1'b1;
                ram_waddr  = count[IDX_W-1:0];
                ram_wdata  = req.entry_weight[WEIGHT_BITS-1:0];
                count_next = count + CNT_W'(1);
              end else begin
                res_status_next = ST_FULL;
              end
            end
            OP_DELETE: begin
              ptr_next = req.entry_index;
              if (!del_ok) begin
                res_status_next = ST_BAD_INDEX;
              end else if (!del_shift) begin
                count_next = count - CNT_W'(1);
              end
            end
            OP_PICK: begin
              if (!pick_ok) begin
                res_status_next = ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_PICK: begin
        // Data for entry ptr arrives now; the next entry is requested.
        ptr_next = IDX_W'(CNT_W'(ptr) + CNT_W'(1));
        if (pick_hit) begin
          res_picked_next = ptr;
        end
      end
      S_DEL: begin
        // Entry ptr+1 arrives now and moves down to ptr.
        ram_we    = 1'b1;
        ram_raddr = IDX_W'(CNT_W'(ptr) + CNT_W'(2));
        ptr_next  = IDX_W'(CNT_W'(ptr) + CNT_W'(1));
        if (del_last) begin
          count_next = count - CNT_W'(1);
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    res_status <= res_status_next;
    res_picked <= res_picked_next;
    if (state == S_IDLE) begin
      sum    <= '0;
      draw_q <= req.draw;
    end else if (state == S_PICK) begin
      sum <= sum_next;
    end
    if (state == S_DONE && out_free) begin
      rsp.status       <= res_status;
      rsp.picked_index <= res_picked;
      rsp.entry_count  <= count;
    end
  end

  // The table never grows past its capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count exceeds capacity");

  // A pick scan never runs past the last entry.
  a_pick_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_PICK |-> CNT_W'(ptr) < count)
    else $error("pick scan beyond table end");

  // A delete shift always has a source entry inside the table.
  a_del_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DEL |-> (CNT_W'(ptr) + CNT_W'(1)) < count)
    else $error("delete shift beyond table end");

  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second request accepted while one is in work");

  // A new result appears only at the end of an operation.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_DONE)
    else $error("result presented outside the done state");

endmodule
